// ===== src/physical_page_bitmap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Physical page bitmap allocator assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef PHYSICAL_PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PHYSICAL_PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PPBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PPBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ppba_pkg.sv =====
// ----------------------------------------------------------------------------
// ppba_pkg
// Shared widths, codes and helpers of the physical page bitmap allocator.
// ----------------------------------------------------------------------------
package ppba_pkg;

   // Field widths
   localparam int PAGE_W    = 18;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int BIT_W     = 5;
   localparam int WORD_BITS = 32;

   // Parameter defaults
   localparam int PAGE_COUNT_DEFAULT = 262144;
   localparam int HUGE_WORDS_DEFAULT = 32;

   // Register reset value
   localparam logic [PAGE_W-1:0] RESERVED_LIMIT_RESET = 18'h01000;

   localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC_PAGE = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_HUGE = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE_PAGE  = 3'd2;
   localparam logic [OP_W-1:0] OP_FREE_HUGE  = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD_PAGE   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   // Index of the lowest clear bit of a word (word must not be all ones)
   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] value);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!value[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/ppba_ram.sv =====
// ----------------------------------------------------------------------------
// ppba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ppba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/physical_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// physical_page_bitmap_allocator
// Next-fit page allocator over a used-page bitmap held in one RAM.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the RAM has one read and one write port
// and a registered read. A page allocation streams bitmap words from the
// resume word, one per cycle, until it reads one with a clear bit, or until
// every word has been read and the search has found nothing. A huge
// allocation reads words 0 upward, one per cycle, until an all-clear group,
// then writes its HUGE_WORDS words. A huge free writes its HUGE_WORDS words;
// a page free or add reads the word and writes it back. After reset the
// block writes all ones over the bitmap before it takes an item; csr writes
// are taken at any time.
`include "physical_page_bitmap_allocator_macros.svh"

module physical_page_bitmap_allocator
   import ppba_pkg::*;
#(
   parameter int PAGE_COUNT = PAGE_COUNT_DEFAULT,
   parameter int HUGE_WORDS = HUGE_WORDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [PAGE_W-1:0]   req_page_number,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_result_page,
   // configuration
   input  logic                csr_write_enable,
   input  logic [PAGE_W-1:0]   csr_write_data
);

   localparam int MAP_WORDS   = PAGE_COUNT / WORD_BITS;
   localparam int WORD_W      = $clog2(MAP_WORDS);
   localparam int CNT_W       = WORD_W + 1;
   localparam int WIN_W       = PAGE_W - BIT_W;
   localparam int XW          = ((WORD_W > WIN_W) ? WORD_W : WIN_W) + 1;
   localparam int OFF_W       = $clog2(HUGE_WORDS + 1);
   localparam int GROUPS      = MAP_WORDS / HUGE_WORDS;
   localparam int HSCAN_WORDS = GROUPS * HUGE_WORDS;
   localparam int DIV_SH      = WIN_W + 7;
   localparam int RECIP_W     = DIV_SH + 1;
   localparam int RECIP       = (2 ** DIV_SH + HUGE_WORDS - 1) / HUGE_WORDS;
   localparam int PROD_W      = WIN_W + RECIP_W;

   localparam logic [CNT_W-1:0]  MAP_WORDS_C = CNT_W'(MAP_WORDS);
   localparam logic [WORD_W-1:0] LAST_WORD   = WORD_W'(MAP_WORDS - 1);
   localparam logic [OFF_W-1:0]  LAST_OFF    = OFF_W'(HUGE_WORDS - 1);

   // Sequencer states
   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_SCAN  = 4'd2;
   localparam logic [3:0] ST_HSCAN = 4'd3;
   localparam logic [3:0] ST_RMW   = 4'd4;
   localparam logic [3:0] ST_BASE  = 4'd5;
   localparam logic [3:0] ST_FILL  = 4'd6;
   localparam logic [3:0] ST_RESP  = 4'd7;

   // Control registers
   logic [3:0]          state_ff, state_in;
   logic [WORD_W-1:0]   iss_ff, iss_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                pend_ff, pend_in;
   logic                bad_ff, bad_in;
   logic [OFF_W-1:0]    ioff_ff, ioff_in;
   logic [OFF_W-1:0]    poff_ff, poff_in;
   logic [OFF_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    resume_ff, resume_in;
   logic [PAGE_W-1:0]   limit_ff, limit_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [WORD_W-1:0]   paddr_ff, paddr_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [WIN_W-1:0]    quo_ff, quo_in;
   logic [XW-1:0]       fill_ff, fill_in;
   logic                fill_full_ff, fill_full_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;

   // RAM ports
   logic                 ram_wr_en;
   logic [WORD_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [WORD_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // Datapath helpers
   logic [WIN_W-1:0]          req_word;
   logic [BIT_W-1:0]          req_bit;
   logic                      req_in_map;
   logic [PROD_W-1:0]         quo_prod;
   logic [BIT_W-1:0]          zero_bit;
   logic [WORD_W+BIT_W-1:0]   found_page;
   logic                      scan_found;
   logic                      cur_bad;
   logic [WORD_W-1:0]         group_base;
   logic [XW-1:0]             fill_addr;

   ppba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Decode request and bitmap word
   assign req_word   = req_page_number[PAGE_W-1:BIT_W];
   assign req_bit    = req_page_number[BIT_W-1:0];
   assign req_in_map = XW'(req_word) < XW'(MAP_WORDS);
   assign quo_prod   = PROD_W'(req_word) * PROD_W'(RECIP);
   assign zero_bit   = lowest_zero(ram_rd_data);
   assign found_page = {paddr_ff, zero_bit};
   assign scan_found = pend_ff && (ram_rd_data != FULL_WORD);
   assign cur_bad    = ((poff_ff != '0) && bad_ff) || (ram_rd_data != '0);
   assign group_base = paddr_ff - WORD_W'(HUGE_WORDS - 1);
   assign fill_addr  = fill_ff + XW'(cnt_ff);

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      bad_in        = bad_ff;
      ioff_in       = ioff_ff;
      poff_in       = poff_ff;
      cnt_in        = cnt_ff;
      resume_in     = resume_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff;
      paddr_in      = paddr_ff;
      bit_in        = bit_ff;
      quo_in        = quo_ff;
      fill_in       = fill_ff;
      fill_full_in  = fill_full_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = paddr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = iss_ff;

      // Drop the response once transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Take configuration writes at any time
      if (csr_write_enable) begin
         limit_in = csr_write_data;
      end

      unique case (state_ff)
         // Sweep all ones over the bitmap
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = iss_ff;
            ram_wr_data = FULL_WORD;
            if (iss_ff == LAST_WORD) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end else begin
               iss_in = iss_ff + 1'b1;
            end
         end

         // Accept a request and start its operation
         ST_IDLE: begin
            if (req_valid) begin
               bit_in        = req_bit;
               paddr_in      = WORD_W'(req_word);
               res_status_in = STATUS_DONE;
               res_page_in   = '0;
               state_in      = ST_RESP;
               unique case (req_op)
                  OP_ALLOC_PAGE: begin
                     iss_in   = (resume_ff == MAP_WORDS_C) ? '0 : resume_ff[WORD_W-1:0];
                     left_in  = MAP_WORDS_C;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_ALLOC_HUGE: begin
                     if (GROUPS == 0) begin
                        res_status_in = STATUS_NO_FREE;
                     end else begin
                        iss_in   = '0;
                        left_in  = CNT_W'(HSCAN_WORDS);
                        ioff_in  = '0;
                        pend_in  = 1'b0;
                        bad_in   = 1'b0;
                        state_in = ST_HSCAN;
                     end
                  end
                  OP_FREE_PAGE: begin
                     if (req_in_map) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = WORD_W'(req_word);
                        state_in    = ST_RMW;
                     end
                  end
                  OP_FREE_HUGE: begin
                     quo_in   = WIN_W'(quo_prod >> DIV_SH);
                     state_in = ST_BASE;
                  end
                  OP_ADD_PAGE: begin
                     if (req_page_number <= limit_ff || !req_in_map) begin
                        res_status_in = STATUS_REJECTED;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = WORD_W'(req_word);
                        state_in    = ST_RMW;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Stream words from the resume word, wrapping, until one has a clear bit
         ST_SCAN: begin
            if (scan_found) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = paddr_ff;
               ram_wr_data   = ram_rd_data | (WORD_BITS'(1) << zero_bit);
               res_page_in   = PAGE_W'(found_page);
               res_status_in = STATUS_DONE;
               resume_in     = (zero_bit == BIT_W'(WORD_BITS - 1)) ?
                               CNT_W'(paddr_ff) + 1'b1 : CNT_W'(paddr_ff);
               state_in      = ST_RESP;
            end else if (!pend_ff && left_ff == '0) begin
               res_status_in = STATUS_NO_FREE;
               res_page_in   = '0;
               state_in      = ST_RESP;
            end else if (left_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = iss_ff;
               pend_in     = 1'b1;
               paddr_in    = iss_ff;
               iss_in      = (iss_ff == LAST_WORD) ? '0 : iss_ff + 1'b1;
               left_in     = left_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end

         // Stream words from zero, tracking whether the current group is all clear
         ST_HSCAN: begin
            if (pend_ff && poff_ff == LAST_OFF && !cur_bad) begin
               fill_in       = XW'(group_base);
               fill_full_in  = 1'b1;
               cnt_in        = '0;
               res_page_in   = PAGE_W'({group_base, BIT_W'(0)});
               res_status_in = STATUS_DONE;
               resume_in     = CNT_W'(group_base) + CNT_W'(HUGE_WORDS);
               state_in      = ST_FILL;
            end else if (!pend_ff && left_ff == '0) begin
               res_status_in = STATUS_NO_FREE;
               res_page_in   = '0;
               state_in      = ST_RESP;
            end else begin
               if (pend_ff) begin
                  bad_in = cur_bad;
               end
               if (left_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = iss_ff;
                  pend_in     = 1'b1;
                  paddr_in    = iss_ff;
                  poff_in     = ioff_ff;
                  iss_in      = iss_ff + 1'b1;
                  ioff_in     = (ioff_ff == LAST_OFF) ? '0 : ioff_ff + 1'b1;
                  left_in     = left_ff - 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end

         // Clear the addressed bit in the word just read
         ST_RMW: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = paddr_ff;
            ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
            state_in    = ST_RESP;
         end

         // Form the group base word of a huge free
         ST_BASE: begin
            fill_in      = XW'(XW'(quo_ff) * XW'(HUGE_WORDS));
            fill_full_in = 1'b0;
            cnt_in       = '0;
            state_in     = ST_FILL;
         end

         // Write a whole group, skipping words past the bitmap
         ST_FILL: begin
            if (fill_addr < XW'(MAP_WORDS)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = WORD_W'(fill_addr);
               ram_wr_data = fill_full_ff ? FULL_WORD : '0;
            end
            if (cnt_ff == LAST_OFF) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Hand the result to the output register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         iss_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         ioff_ff      <= '0;
         poff_ff      <= '0;
         cnt_ff       <= '0;
         resume_ff    <= '0;
         limit_ff     <= RESERVED_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         bad_ff       <= bad_in;
         ioff_ff      <= ioff_in;
         poff_ff      <= poff_in;
         cnt_ff       <= cnt_in;
         resume_ff    <= resume_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      paddr_ff      <= paddr_in;
      bit_ff        <= bit_in;
      quo_ff        <= quo_in;
      fill_ff       <= fill_in;
      fill_full_ff  <= fill_full_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_page = rsp_page_ff;

   // Checks
   `PPBA_ASSERT_SAME(a_no_rw_collision, clock, reset,
      ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
      "bitmap read and write hit the same word in one cycle")
   `PPBA_ASSERT_SAME(a_claim_sets_bit, clock, reset,
      state_ff == ST_SCAN && scan_found, ram_wr_en && ram_wr_data != ram_rd_data,
      "page allocation did not mark a new bit used")
   `PPBA_ASSERT_NEXT(a_resp_loads, clock, reset,
      state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == ST_IDLE,
      "finished result was not moved to the response register")
   `PPBA_ASSERT_SAME(a_resume_in_range, clock, reset,
      state_ff == ST_IDLE, resume_ff <= MAP_WORDS_C,
      "resume word beyond the bitmap")

endmodule
